// File: rtl/core/pcrt_pkg.sv
// Shared constants, types and codes for the pixel color replacement table.
// Used by the channel interfaces and by the top level. No dependencies.
package pcrt_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 32;
	localparam int ENTRY_W     = $clog2(MAX_ENTRIES);

	// Field widths of the channels.
	localparam int INDEX_W  = 5;
	localparam int COLOR_W  = 24;
	localparam int PIXEL_W  = 32;
	localparam int COUNT_W  = 6;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	// Item kinds on the input channel.
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ONLY_MODE   = 1'b0,
		CFG_ENTRY_COUNT = 1'b1
	} cfg_reg_t;

	// Color given to unmatched pixels in only mode.
	localparam color_t CLEAR_COLOR = '0;

endpackage

// File: rtl/core/pcrt_if.sv
// Valid/ready channel interfaces for the pixel color replacement table.
// Depends on pcrt_pkg for field types.
interface pcrt_in_if import pcrt_pkg::*; ();
	logic    valid;
	logic    ready;
	opcode_t opcode;
	index_t  entry_index;
	color_t  match_color;
	color_t  replace_color;
	pixel_t  pixel_in;

	modport source (output valid, output opcode, output entry_index, output match_color,
		output replace_color, output pixel_in, input ready);
	modport sink (input valid, input opcode, input entry_index, input match_color,
		input replace_color, input pixel_in, output ready);
endinterface

interface pcrt_out_if import pcrt_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t pixel_out;
	logic   matched;
	index_t match_slot;

	modport source (output valid, output pixel_out, output matched, output match_slot,
		input ready);
	modport sink (input valid, input pixel_out, input matched, input match_slot,
		output ready);
endinterface

// File: rtl/core/pixel_color_replace_table.sv
// Pixel color replacement table: color-key lookup over a 32-bit pixel stream.
// Depends on pcrt_pkg and on the channel interfaces in pcrt_if.sv.
//
// Usage:
// The input channel carries two kinds of items. A load item writes one pair of
// source and target colors into the table slot given by entry_index and gives
// no result. A pixel item compares its low 24 bits against the first
// entry_count source colors; the lowest matching slot replaces the color with
// its target color. An unmatched color passes unchanged, or is cleared to zero
// when only_mode is set. Alpha in the top byte always passes through.
// The two configuration registers are written through cfg_we, cfg_index and
// cfg_wdata while no item is in flight.
// A pixel result is presented from the output register, after stages 1 and 2.
// Throughput: one item per cycle while out_ch.ready holds; the three register
// stages (parallel compare, priority encode, target select) each hold one item.
// Each stage moves when the stage after it is empty or moving, so bubbles are
// squeezed out and input is taken while a result waits at the output register.
// When the receiver stalls, items collect in the stages until all are full and
// then ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits and both registers. Table slots are not
// cleared; a slot must be loaded before it is used for matching.
module pixel_color_replace_table import pcrt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pcrt_in_if.sink               in_ch,
	pcrt_out_if.source            out_ch
);

	// Configuration registers.
	logic   only_mode_q;
	count_t entry_count_q;

	// Table storage.
	color_t source_q [MAX_ENTRIES];
	color_t target_q [MAX_ENTRIES];

	// Stage 1: compare results.
	logic                   v_s1;
	opcode_t                op_s1;
	logic                   wen_s1;
	index_t                 eidx_s1;
	color_t                 repl_s1;
	pixel_t                 pixel_s1;
	logic [MAX_ENTRIES-1:0] hits_s1;

	// Stage 2: encoded match.
	logic    v_s2;
	opcode_t op_s2;
	logic    wen_s2;
	index_t  eidx_s2;
	color_t  repl_s2;
	pixel_t  pixel_s2;
	logic    matched_s2;
	entry_t  slot_s2;

	// Stage 3: output register.
	logic   v_s3;
	pixel_t pixel_s3;
	logic   matched_s3;
	index_t slot_s3;

	logic                   adv1, adv2, adv3;
	logic                   in_xfer;
	logic                   load_ok;
	logic [MAX_ENTRIES-1:0] hits_c;
	logic                   found_c;
	entry_t                 slot_c;
	color_t                 color_c;

	// Stage advance: a stage moves when it is empty or the next one moves.
	assign adv3        = !v_s3 || out_ch.ready;
	assign adv2        = !v_s2 || adv3;
	assign adv1        = !v_s1 || adv2;
	assign in_ch.ready = adv1;
	assign in_xfer     = in_ch.valid && adv1;
	assign load_ok     = (int'(in_ch.entry_index) < MAX_ENTRIES);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			only_mode_q   <= 1'b0;
			entry_count_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ONLY_MODE) begin
				only_mode_q <= cfg_wdata[0];
			end else if (cfg_index == CFG_ENTRY_COUNT) begin
				entry_count_q <= cfg_wdata[COUNT_W-1:0];
			end
		end
	end

	// Source colors are written at the input transfer, where they are compared.
	always_ff @(posedge clk) begin
		if (in_xfer && in_ch.opcode == OP_LOAD && load_ok) begin
			source_q[in_ch.entry_index[ENTRY_W-1:0]] <= in_ch.match_color;
		end
	end

	// Parallel compare against every slot in use.
	always_comb begin
		for (int k = 0; k < MAX_ENTRIES; k++) begin
			hits_c[k] = (source_q[k] == in_ch.pixel_in[COLOR_W-1:0])
				&& (k < int'(entry_count_q));
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_xfer;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2 && (op_s2 == OP_PIXEL);
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1    <= in_ch.opcode;
			wen_s1   <= load_ok;
			eidx_s1  <= in_ch.entry_index;
			repl_s1  <= in_ch.replace_color;
			pixel_s1 <= in_ch.pixel_in;
			hits_s1  <= hits_c;
		end
	end

	// Priority encoder: the lowest set hit wins.
	always_comb begin
		found_c = 1'b0;
		slot_c  = '0;
		for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
			if (hits_s1[k]) begin
				found_c = 1'b1;
				slot_c  = ENTRY_W'(k);
			end
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (adv2) begin
			op_s2      <= op_s1;
			wen_s2     <= wen_s1;
			eidx_s2    <= eidx_s1;
			repl_s2    <= repl_s1;
			pixel_s2   <= pixel_s1;
			matched_s2 <= found_c;
			slot_s2    <= slot_c;
		end
	end

	// Target colors are written where they are read, so every pixel sees the
	// same table state in both lookups.
	always_ff @(posedge clk) begin
		if (adv3 && v_s2 && op_s2 == OP_LOAD && wen_s2) begin
			target_q[eidx_s2[ENTRY_W-1:0]] <= repl_s2;
		end
	end

	// Pick the new color.
	always_comb begin
		priority if (matched_s2) begin
			color_c = target_q[slot_s2];
		end else if (only_mode_q) begin
			color_c = CLEAR_COLOR;
		end else begin
			color_c = pixel_s2[COLOR_W-1:0];
		end
	end

	// Stage 3 payload: the output register.
	always_ff @(posedge clk) begin
		if (adv3) begin
			pixel_s3   <= {pixel_s2[PIXEL_W-1:COLOR_W], color_c};
			matched_s3 <= matched_s2;
			slot_s3    <= INDEX_W'(slot_s2);
		end
	end

	assign out_ch.valid      = v_s3;
	assign out_ch.pixel_out  = pixel_s3;
	assign out_ch.matched    = matched_s3;
	assign out_ch.match_slot = slot_s3;

	// An unmatched result reports slot zero.
	a_nomatch_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !matched_s3) |-> (slot_s3 == '0))
		else $error("unmatched pixel carries a nonzero slot");

	// A matched slot lies inside the active part of the table.
	a_match_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && matched_s3) |-> (COUNT_W'(slot_s3) < entry_count_q))
		else $error("matched slot beyond entry count");

	// A load item never reaches the output register.
	a_load_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(adv3 && v_s2 && op_s2 == OP_LOAD) |=> !v_s3)
		else $error("load item produced a result");

endmodule
